// File: hdl/hnf_pkg.sv
`timescale 1ns / 1ps

package hnf_pkg;

    // Field and register widths
    localparam int K_W        = 32;
    localparam int SC_W       = 31;
    localparam int AREA_W     = 24;
    localparam int SLOPE_W    = 32;
    localparam int HEIGHT_W   = 32;
    localparam int DIST_W     = 32;
    localparam int FLUX_W     = 63;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Divider geometry: dividend is pre-shifted by 24, quotient saturates at 63 bits
    localparam int DSR_W   = 62;
    localparam int Q_W     = FLUX_W;
    localparam int NUM_W   = 101;
    localparam int NTOP_W  = NUM_W - Q_W;

    // Tangent line, folded: T = 198010000*S - 194059800*Sc
    localparam int TAN_S_COEF  = 198010000;
    localparam int TAN_SC_COEF = 194059800;
    localparam int TAN_DENOM   = 39601;
    localparam int BAND_FACTOR = 200000000;

    localparam logic [FLUX_W-1:0] FLUX_MAX = '1;

    localparam logic [K_W-1:0]    K_RESET    = 32'd298309;
    localparam logic [SC_W-1:0]   SC_RESET   = 31'd9686330;
    localparam logic [AREA_W-1:0] AREA_RESET = 24'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIFFUSIVITY    = 2'd0,
        REG_CRITICAL_SLOPE = 2'd1,
        REG_CELL_AREA      = 2'd2
    } cfg_reg_t;

    // One item in flight through the divider: partial remainder, the dividend
    // bits not yet consumed (quotient bits shift in from the bottom), divisor
    typedef struct packed {
        logic [DSR_W-1:0] rem;
        logic [Q_W-1:0]   bits;
        logic [DSR_W-1:0] dsr;
        logic             sat;
    } div_item_t;

endpackage

// File: hdl/hnf_front.sv
`timescale 1ns / 1ps

module hnf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic                          no_donor,
    input  logic [hnf_pkg::SLOPE_W-1:0]   slope,
    input  logic [hnf_pkg::HEIGHT_W-1:0]  height,
    input  logic [hnf_pkg::HEIGHT_W-1:0]  receiver_height,
    input  logic [hnf_pkg::DIST_W-1:0]    receiver_distance,
    input  logic [hnf_pkg::K_W-1:0]       diffusivity,
    input  logic [hnf_pkg::SC_W-1:0]      critical_slope,
    input  logic [hnf_pkg::AREA_W-1:0]    cell_area,
    output logic                          out_valid,
    output hnf_pkg::div_item_t            out_item
);
    import hnf_pkg::*;

    typedef enum logic [1:0] {
        RGN_ZERO,
        RGN_CURVE,
        RGN_TANGENT,
        RGN_EXCESS
    } region_t;

    // ---------------- stage 1: classify, base products ----------------
    logic [30:0]  s_mag;
    logic         s_pos;
    logic [37:0]  s100;
    logic [37:0]  sc99;
    logic [58:0]  sc_band;
    logic         band;
    logic [59:0]  t_full;
    region_t      rgn;

    always_comb
    begin
        s_mag   = slope[30:0];
        s_pos   = !slope[31] && (|slope[30:0]);
        s100    = 38'(s_mag) * 38'd100;
        sc99    = 38'(critical_slope) * 38'd99;
        sc_band = 59'(critical_slope) * 59'(BAND_FACTOR);
        band    = no_donor ? (s_mag < critical_slope) : (59'(s_mag) < sc_band);
        t_full  = 60'(s_mag) * 60'(TAN_S_COEF) - 60'(critical_slope) * 60'(TAN_SC_COEF);
        if (!s_pos)
            rgn = RGN_ZERO;
        else if (s100 < sc99)
            rgn = RGN_CURVE;
        else if (band)
            rgn = RGN_TANGENT;
        else
            rgn = RGN_EXCESS;
    end

    logic               p1_valid_reg;
    region_t            p1_rgn_reg;
    logic               p1_nodon_reg;
    logic [62:0]        p1_ks_reg;
    logic [61:0]        p1_sc2_reg;
    logic [61:0]        p1_ss_reg;
    logic [62:0]        p1_scd_reg;
    logic signed [32:0] p1_dh_reg;
    logic [58:0]        p1_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (en)
            p1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_rgn_reg   <= rgn;
            p1_nodon_reg <= no_donor;
            p1_ks_reg    <= 63'(diffusivity) * 63'(s_mag);
            p1_sc2_reg   <= 62'(critical_slope) * 62'(critical_slope);
            p1_ss_reg    <= 62'(s_mag) * 62'(s_mag);
            p1_scd_reg   <= 63'(critical_slope) * 63'(receiver_distance);
            p1_dh_reg    <= $signed({height[31], height})
                            - $signed({receiver_height[31], receiver_height});
            p1_t_reg     <= t_full[58:0];
        end
    end

    // ---------------- stage 2: partial products, excess height ----------------
    logic signed [64:0] exv;
    logic [47:0]        ex;

    always_comb
    begin
        exv = 65'($signed({p1_dh_reg, 24'd0})) - $signed({2'b00, p1_scd_reg});
        ex  = (!exv[64] && (|exv[63:0])) ? exv[55:8] : 48'd0;
    end

    logic        p2_valid_reg;
    region_t     p2_rgn_reg;
    logic        p2_nodon_reg;
    logic [61:0] p2_den_reg;
    logic [63:0] p2_ll_reg;
    logic [61:0] p2_lh_reg;
    logic [62:0] p2_hl_reg;
    logic [60:0] p2_hh_reg;
    logic [63:0] p2_ktl_reg;
    logic [58:0] p2_kth_reg;
    logic [47:0] p2_ex_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (en)
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_rgn_reg   <= p1_rgn_reg;
            p2_nodon_reg <= p1_nodon_reg;
            p2_den_reg   <= p1_sc2_reg - p1_ss_reg;
            p2_ll_reg    <= 64'(p1_ks_reg[31:0]) * 64'(p1_sc2_reg[31:0]);
            p2_lh_reg    <= 62'(p1_ks_reg[31:0]) * 62'(p1_sc2_reg[61:32]);
            p2_hl_reg    <= 63'(p1_ks_reg[62:32]) * 63'(p1_sc2_reg[31:0]);
            p2_hh_reg    <= 61'(p1_ks_reg[62:32]) * 61'(p1_sc2_reg[61:32]);
            p2_ktl_reg   <= 64'(diffusivity) * 64'(p1_t_reg[31:0]);
            p2_kth_reg   <= 59'(diffusivity) * 59'(p1_t_reg[58:32]);
            p2_ex_reg    <= ex;
        end
    end

    // ---------------- stage 3: sum partials, area partials ----------------
    logic         p3_valid_reg;
    region_t      p3_rgn_reg;
    logic         p3_nodon_reg;
    logic [61:0]  p3_den_reg;
    logic [124:0] p3_num_reg;
    logic [90:0]  p3_kt_reg;
    logic [47:0]  p3_eal_reg;
    logic [47:0]  p3_eah_reg;
    logic [47:0]  p3_ex_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_valid_reg <= 1'b0;
        else if (en)
            p3_valid_reg <= p2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_rgn_reg   <= p2_rgn_reg;
            p3_nodon_reg <= p2_nodon_reg;
            p3_den_reg   <= p2_den_reg;
            p3_num_reg   <= 125'(p2_ll_reg) + (125'(p2_lh_reg) << 32)
                            + (125'(p2_hl_reg) << 32) + (125'(p2_hh_reg) << 64);
            p3_kt_reg    <= 91'(p2_ktl_reg) + (91'(p2_kth_reg) << 32);
            p3_eal_reg   <= 48'(p2_ex_reg[23:0]) * 48'(cell_area);
            p3_eah_reg   <= 48'(p2_ex_reg[47:24]) * 48'(cell_area);
            p3_ex_reg    <= p2_ex_reg;
        end
    end

    // ---------------- stage 4: choose dividend and divisor ----------------
    logic [71:0]       ea;
    logic [FLUX_W-1:0] ex_f;
    logic [NUM_W-1:0]  nl;
    logic [DSR_W-1:0]  dsr;

    always_comb
    begin
        ea   = 72'(p3_eal_reg) + (72'(p3_eah_reg) << 24);
        ex_f = p3_nodon_reg ? ((|ea[71:63]) ? FLUX_MAX : ea[62:0]) : 63'(p3_ex_reg);
        case (p3_rgn_reg)
            RGN_CURVE:
            begin
                nl  = p3_num_reg[124:24];
                dsr = p3_den_reg;
            end
            RGN_TANGENT:
            begin
                nl  = NUM_W'(p3_kt_reg[90:24]);
                dsr = DSR_W'(TAN_DENOM);
            end
            RGN_EXCESS:
            begin
                nl  = NUM_W'(ex_f);
                dsr = DSR_W'(1);
            end
            default:
            begin
                nl  = '0;
                dsr = DSR_W'(1);
            end
        endcase
    end

    logic             p4_valid_reg;
    logic [NUM_W-1:0] p4_nl_reg;
    logic [DSR_W-1:0] p4_dsr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p4_valid_reg <= 1'b0;
        else if (en)
            p4_valid_reg <= p3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_nl_reg  <= nl;
            p4_dsr_reg <= dsr;
        end
    end

    // ---------------- stage 5: overflow check, divider setup ----------------
    logic [DSR_W-1:0] top;
    logic             ovf;

    always_comb
    begin
        top = DSR_W'(p4_nl_reg[NUM_W-1:Q_W]);
        ovf = top >= p4_dsr_reg;
    end

    logic      p5_valid_reg;
    div_item_t p5_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p5_valid_reg <= 1'b0;
        else if (en)
            p5_valid_reg <= p4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p5_item_reg.rem  <= ovf ? '0 : top;
            p5_item_reg.bits <= p4_nl_reg[Q_W-1:0];
            p5_item_reg.dsr  <= p4_dsr_reg;
            p5_item_reg.sat  <= ovf;
        end
    end

    assign out_valid = p5_valid_reg;
    assign out_item  = p5_item_reg;

endmodule

// File: hdl/hnf_div.sv
`timescale 1ns / 1ps

module hnf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  hnf_pkg::div_item_t in_item,
    output logic               out_valid,
    output hnf_pkg::div_item_t out_item
);
    import hnf_pkg::*;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    function automatic div_item_t div_step(input div_item_t x);
        logic [DSR_W:0] trial;
        logic           ge;
        div_item_t      y;
        trial  = {x.rem, x.bits[Q_W-1]};
        ge     = trial >= {1'b0, x.dsr};
        y      = x;
        y.rem  = ge ? DSR_W'(trial - {1'b0, x.dsr}) : trial[DSR_W-1:0];
        y.bits = {x.bits[Q_W-2:0], ge};
        return y;
    endfunction

    logic [Q_W-1:0] vld_reg;
    logic [Q_W-1:0] vin;
    div_item_t      stg_reg [Q_W];
    div_item_t      stg_in  [Q_W];

    always_comb
    begin
        vin[0]    = in_valid;
        stg_in[0] = in_item;
        for (int j = 1; j < Q_W; j++)
        begin
            vin[j]    = vld_reg[j-1];
            stg_in[j] = stg_reg[j-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < Q_W; j++)
                stg_reg[j] <= div_step(stg_in[j]);
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign out_item  = stg_reg[Q_W-1];

endmodule

// File: hdl/hnf_scale.sv
`timescale 1ns / 1ps

module hnf_scale (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  hnf_pkg::div_item_t          in_item,
    input  logic [hnf_pkg::AREA_W-1:0]  cell_area,
    output logic                        out_valid,
    output logic [hnf_pkg::FLUX_W-1:0]  out_flux
);
    import hnf_pkg::*;

    logic [FLUX_W-1:0] f;

    assign f = in_item.sat ? FLUX_MAX : in_item.bits;

    // Split the 63x24 area product into two halves
    logic        m1_valid_reg;
    logic [55:0] m1_lo_reg;
    logic [54:0] m1_hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_valid_reg <= 1'b0;
        else if (en)
            m1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_lo_reg <= 56'(f[31:0]) * 56'(cell_area);
            m1_hi_reg <= 55'(f[62:32]) * 55'(cell_area);
        end
    end

    logic [86:0] prod;

    assign prod = 87'(m1_lo_reg) + (87'(m1_hi_reg) << 32);

    logic              m2_valid_reg;
    logic [FLUX_W-1:0] m2_flux_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m2_valid_reg <= 1'b0;
        else if (en)
            m2_valid_reg <= m1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            m2_flux_reg <= (|prod[86:63]) ? FLUX_MAX : prod[62:0];
    end

    assign out_valid = m2_valid_reg;
    assign out_flux  = m2_flux_reg;

endmodule

// File: hdl/nonlinear_hillslope_flux.sv
`timescale 1ns / 1ps

// Nonlinear hillslope flux engine: one grid node in, one flux value out.
//
// Node channel (node_valid / node_ready) carries no_donor, slope, height,
// receiver_height and receiver_distance. Flux channel (flux_valid /
// flux_ready) returns the saturated unsigned Q39.24 flux times cell area, in order.
// Registers diffusivity, critical_slope and cell_area are loaded through
// cfg_wen / cfg_index / cfg_wdata; write them only while the block is empty.
//
// Throughput: one node per cycle while the skid is empty. A node passes five
// front stages, the 63-stage restoring divider (one quotient bit per stage),
// two area-product stages and the output register before flux_valid.
//
// Reset clears every valid bit and loads the register defaults; the block
// accepts a node in the first cycle after reset.
// When the receiver stalls, the output register holds its item and a
// one-entry skid buffer catches the item leaving the pipeline; the whole
// pipeline then freezes and node_ready drops until the skid drains.
module nonlinear_hillslope_flux (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [hnf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hnf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            node_valid,
    output logic                            node_ready,
    input  logic                            no_donor,
    input  logic [hnf_pkg::SLOPE_W-1:0]     slope,
    input  logic [hnf_pkg::HEIGHT_W-1:0]    height,
    input  logic [hnf_pkg::HEIGHT_W-1:0]    receiver_height,
    input  logic [hnf_pkg::DIST_W-1:0]      receiver_distance,
    output logic                            flux_valid,
    input  logic                            flux_ready,
    output logic [hnf_pkg::FLUX_W-1:0]      flux
);
    import hnf_pkg::*;

    // Configuration registers
    logic [K_W-1:0]    k_reg;
    logic [SC_W-1:0]   sc_reg;
    logic [AREA_W-1:0] area_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= K_RESET;
            sc_reg   <= SC_RESET;
            area_reg <= AREA_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_DIFFUSIVITY:    k_reg    <= cfg_wdata;
                REG_CRITICAL_SLOPE: sc_reg   <= cfg_wdata[SC_W-1:0];
                REG_CELL_AREA:      area_reg <= cfg_wdata[AREA_W-1:0];
                default:            ;   // drop writes to unused indexes
            endcase
        end
    end

    // Pipeline advances as one while the skid buffer is empty
    logic en;
    logic skid_full_reg;

    assign en         = !skid_full_reg;
    assign node_ready = en;

    logic      fr_valid;
    div_item_t fr_item;
    logic      dv_valid;
    div_item_t dv_item;
    logic              pv;
    logic [FLUX_W-1:0] pdata;

    hnf_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (en),
        .in_valid          (node_valid),
        .no_donor          (no_donor),
        .slope             (slope),
        .height            (height),
        .receiver_height   (receiver_height),
        .receiver_distance (receiver_distance),
        .diffusivity       (k_reg),
        .critical_slope    (sc_reg),
        .cell_area         (area_reg),
        .out_valid         (fr_valid),
        .out_item          (fr_item)
    );

    hnf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_item   (fr_item),
        .out_valid (dv_valid),
        .out_item  (dv_item)
    );

    hnf_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_valid),
        .in_item   (dv_item),
        .cell_area (area_reg),
        .out_valid (pv),
        .out_flux  (pdata)
    );

    // Output register plus one-entry skid
    logic              flux_valid_reg;
    logic              flux_valid_next;
    logic              skid_full_next;
    logic [FLUX_W-1:0] flux_reg;
    logic [FLUX_W-1:0] skid_reg;
    logic              out_take;
    logic              load_out;
    logic              load_skid;

    always_comb
    begin
        out_take        = !flux_valid_reg || flux_ready;
        flux_valid_next = flux_valid_reg;
        skid_full_next  = skid_full_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        if (!out_take)
        begin
            // hold the output; catch a leaving item in the skid
            if (en && pv)
            begin
                skid_full_next = 1'b1;
                load_skid      = 1'b1;
            end
        end
        else if (skid_full_reg)
        begin
            // drain the skid; pipeline is frozen this cycle
            flux_valid_next = 1'b1;
            skid_full_next  = 1'b0;
            load_out        = 1'b1;
        end
        else
        begin
            flux_valid_next = pv;
            load_out        = pv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flux_valid_reg <= 1'b0;
            skid_full_reg  <= 1'b0;
        end
        else
        begin
            flux_valid_reg <= flux_valid_next;
            skid_full_reg  <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            flux_reg <= skid_full_reg ? skid_reg : pdata;
        if (load_skid)
            skid_reg <= pdata;
    end

    assign flux_valid = flux_valid_reg;
    assign flux       = flux_reg;

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> flux_valid_reg)
        else $error("skid holds an item while output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(flux_valid_reg && !flux_ready))
        else $error("skid filled without an output stall");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg && flux_ready |=> !skid_full_reg && flux_valid_reg)
        else $error("skid did not drain into output register");
`endif

endmodule
